[rtl/cnv3_pkg.sv]
// Shared types, constants and kernel weights for the 3x3 line-buffer convolution.
// No dependencies; used by the output queue and the top level.
`default_nettype none

package cnv3_pkg;

    localparam int PIX_W        = 8;
    localparam int COL_OUT_W    = 6;
    localparam int ROW_W        = 12;
    localparam int IMG_WIDTH_W  = 7;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 1;
    localparam int LINE_DEPTH_DEF = 64;
    localparam int OUT_Q_DEPTH  = 3;
    localparam int KWEIGHT_W    = 5;

    localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RST  = 7'd64;
    localparam logic [ROW_W-1:0]       IMG_HEIGHT_RST = 12'd64;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } t_result;

    // Kernel weight 11 + 3*dx + dy
    function automatic logic [KWEIGHT_W-1:0] kernel_weight(input logic [1:0] dx,
                                                           input logic [1:0] dy);
        logic [KWEIGHT_W-1:0] w;
        w = 5'd11 + 5'(dx) * 5'd3 + 5'(dy);
        return w;
    endfunction

    // Only the low 8 bits of the sum survive, so every term is kept modulo 256
    function automatic logic [PIX_W-1:0] mac_term(input logic [PIX_W-1:0] p,
                                                  input logic [KWEIGHT_W-1:0] k);
        logic [PIX_W+KWEIGHT_W-1:0] prod;
        prod = (PIX_W+KWEIGHT_W)'(p) * (PIX_W+KWEIGHT_W)'(k);
        return prod[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/cnv3_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module cnv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/cnv3_out_fifo.sv]
// Small register queue that parts the result pipeline from the output channel.
// Depends on cnv3_pkg (t_result).
`default_nettype none

module cnv3_out_fifo #(
    parameter int DEPTH = cnv3_pkg::OUT_Q_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire cnv3_pkg::t_result             i_data,
    output      logic                          o_valid,
    input  wire logic                          i_ready,
    output      cnv3_pkg::t_result             o_data,
    output      logic [$clog2(DEPTH+1)-1:0]    o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH+1);

    cnv3_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic            pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/conv3x3_fixed_kernel_stream.sv]
// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_ready     i_pixel_in
// out       source     o_out_valid / i_out_ready   o_pixel_out, o_out_col, o_out_row, o_frame_last
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One pixel per clock while input is not stalled; a result passes stage 1, then the output queue.
// The line RAM holds two lines side by side in one word: read at acceptance, written
// back the next cycle, so its single read and write ports set the one-pixel-per-cycle rate.
// Reset clears counters, window, pipeline and queue; the line RAM is not cleared.
// Input stalls only when the three-entry result queue plus the result in flight is full.
// Depends on cnv3_pkg, cnv3_ram and cnv3_out_fifo.
`default_nettype none

module conv3x3_fixed_kernel_stream #(
    parameter int LINE_DEPTH = cnv3_pkg::LINE_DEPTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_ready,
    input  wire logic [cnv3_pkg::PIX_W-1:0]           i_pixel_in,
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_ready,
    output      logic [cnv3_pkg::PIX_W-1:0]           o_pixel_out,
    output      logic [cnv3_pkg::COL_OUT_W-1:0]       o_out_col,
    output      logic [cnv3_pkg::ROW_W-1:0]           o_out_row,
    output      logic                                 o_frame_last,
    input  wire logic                                 i_cfg_valid,
    output      logic                                 o_cfg_ready,
    input  wire logic [cnv3_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [cnv3_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int PIX_W = cnv3_pkg::PIX_W;
    localparam int ROW_W = cnv3_pkg::ROW_W;
    localparam int CW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int WW    = ($clog2(LINE_DEPTH+1) > cnv3_pkg::IMG_WIDTH_W) ?
                           $clog2(LINE_DEPTH+1) : cnv3_pkg::IMG_WIDTH_W;
    localparam int QD    = cnv3_pkg::OUT_Q_DEPTH;
    localparam int QCW   = $clog2(QD+1);

    // configuration
    logic [cnv3_pkg::IMG_WIDTH_W-1:0] r_img_width;
    logic [ROW_W-1:0]                 r_img_height;

    // position counters
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    // stage 1: RAM data lands here
    logic                             r_s1_valid;
    logic                             r_s1_emit;
    logic [PIX_W-1:0]                 r_s1_pix;
    logic [CW-1:0]                    r_s1_addr;
    logic [cnv3_pkg::COL_OUT_W-1:0]   r_s1_col_out;
    logic [ROW_W-1:0]                 r_s1_row_out;
    logic                             r_s1_last;

    logic [PIX_W-1:0] r_win [6];

    logic              in_accept;
    logic [WW-1:0]     width_ext;
    logic [WW-1:0]     width_eff;
    logic [ROW_W-1:0]  height_eff;
    logic [WW:0]       col_inc;
    logic [ROW_W:0]    row_inc;
    logic              last_col;
    logic              last_row;
    logic              emit;
    logic [CW-1:0]     col_m2;

    logic [2*PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0]   col_pix [3];
    logic [PIX_W-1:0]   acc;

    cnv3_pkg::t_result s1_result;
    cnv3_pkg::t_result q_data;
    logic [QCW-1:0]    q_count;
    logic              q_push;
    logic [QCW:0]      q_pending;

    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Effective image size
    assign width_ext  = WW'(r_img_width);
    assign width_eff  = (width_ext < WW'(3)) ? WW'(3) :
                        (width_ext > WW'(LINE_DEPTH)) ? WW'(LINE_DEPTH) : width_ext;
    assign height_eff = (r_img_height < ROW_W'(3)) ? ROW_W'(3) : r_img_height;

    assign col_inc  = (WW+1)'(r_col) + (WW+1)'(1);
    assign row_inc  = (ROW_W+1)'(r_row) + (ROW_W+1)'(1);
    assign last_col = (col_inc >= (WW+1)'(width_eff));
    assign last_row = (row_inc >= (ROW_W+1)'(height_eff));
    assign emit     = (r_col >= CW'(2)) && (r_row >= ROW_W'(2));
    assign col_m2   = r_col - CW'(2);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    // Admit a pixel only if its result is sure to find room in the queue
    assign q_pending  = (QCW+1)'(q_count) + (QCW+1)'(r_s1_valid && r_s1_emit);
    assign o_in_ready = (q_pending < (QCW+1)'(QD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= cnv3_pkg::IMG_WIDTH_RST;
            r_img_height <= cnv3_pkg::IMG_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cnv3_pkg::CFG_IMAGE_WIDTH:
                    r_img_width <= i_cfg_data[cnv3_pkg::IMG_WIDTH_W-1:0];
                cnv3_pkg::CFG_IMAGE_HEIGHT:
                    r_img_height <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            r_s1_emit  <= in_accept && emit;
            if (in_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix     <= i_pixel_in;
            r_s1_addr    <= r_col;
            r_s1_col_out <= cnv3_pkg::COL_OUT_W'(col_m2);
            r_s1_row_out <= r_row - ROW_W'(2);
            r_s1_last    <= last_col && last_row;
        end
    end

    // Word layout: upper byte is line r-2, lower byte is line r-1
    cnv3_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata ({ram_rdata[PIX_W-1:0], r_s1_pix}),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign col_pix[0] = ram_rdata[2*PIX_W-1:PIX_W];
    assign col_pix[1] = ram_rdata[PIX_W-1:0];
    assign col_pix[2] = r_s1_pix;

    always_comb begin
        acc = '0;
        for (int dy = 0; dy < 3; dy++) begin
            acc = acc
                + cnv3_pkg::mac_term(r_win[dy],
                                     cnv3_pkg::kernel_weight(2'd0, 2'(dy)))
                + cnv3_pkg::mac_term(r_win[3+dy],
                                     cnv3_pkg::kernel_weight(2'd1, 2'(dy)))
                + cnv3_pkg::mac_term(col_pix[dy],
                                     cnv3_pkg::kernel_weight(2'd2, 2'(dy)));
        end
    end

    // Advance the window by one column per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k]   <= r_win[3+k];
                r_win[3+k] <= col_pix[k];
            end
        end
    end

    assign q_push          = r_s1_valid && r_s1_emit;
    assign s1_result.pixel = acc;
    assign s1_result.col   = r_s1_col_out;
    assign s1_result.row   = r_s1_row_out;
    assign s1_result.last  = r_s1_last;

    cnv3_out_fifo #(
        .DEPTH (QD)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (s1_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_pixel_out  = q_data.pixel;
    assign o_out_col    = q_data.col;
    assign o_out_row    = q_data.row;
    assign o_frame_last = q_data.last;

`ifndef ASSERT_OFF
    // A result must never arrive at a full queue unless an entry leaves in the same cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < QCW'(QD)) || (o_out_valid && i_out_ready))
        else $error("result queue overflow");

    // Write-back and the next read never hit the same line RAM entry
    a_no_raw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && in_accept) |-> (r_s1_addr != r_col))
        else $error("line RAM read and write-back collide");

    // Counters move only on an accepted transaction
    a_counters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> ($stable(r_col) && $stable(r_row)))
        else $error("position counters moved without a transaction");
`endif

endmodule

`default_nettype wire

[sim/conv3x3_fixed_kernel_stream_tb.sv]
// Self-checking bench for conv3x3_fixed_kernel_stream: raster pixel frames with random
// stalls on both channels, predicted 3x3 weighted sums checked in order.
// Depends on cnv3_pkg and the conv3x3_fixed_kernel_stream RTL.

module conv3x3_fixed_kernel_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cnv3_pkg::*;

    localparam int LINE_DEPTH  = LINE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_ALTERNATE} t_fill;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [PIX_W-1:0]       i_pixel_in;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [PIX_W-1:0]       o_pixel_out;
    logic [COL_OUT_W-1:0]   o_out_col;
    logic [ROW_W-1:0]       o_out_row;
    logic                   o_frame_last;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Predictor state: line store, window columns, raster position, image size
    logic [PIX_W-1:0]       line_mem [2*LINE_DEPTH];
    logic [PIX_W-1:0]       win_cols [6];
    int unsigned            col_cnt;
    int unsigned            row_cnt;
    logic [IMG_WIDTH_W-1:0] img_width;
    logic [ROW_W-1:0]       img_height;

    t_result     pending_sums [$];
    t_result     want;
    int          error_count;
    int          sent_count;
    int          cycle_count;
    bit          gaps_on;

    conv3x3_fixed_kernel_stream u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_out  (o_pixel_out),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= gaps_on ? ($urandom_range(99) >= 35) : 1'b1;
    end

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_sums.size() == 0) begin
                report_error($sformatf("unexpected result: pixel=%0d col=%0d row=%0d last=%0b",
                                       o_pixel_out, o_out_col, o_out_row, o_frame_last));
            end else begin
                want = pending_sums.pop_front();
                if (o_pixel_out !== want.pixel || o_out_col !== want.col ||
                    o_out_row !== want.row || o_frame_last !== want.last) begin
                    report_error($sformatf(
                        "mismatch: exp pixel=%0d col=%0d row=%0d last=%0b, got %0d %0d %0d %0b",
                        want.pixel, want.col, want.row, want.last,
                        o_pixel_out, o_out_col, o_out_row, o_frame_last));
                end
            end
        end
    end

    function automatic int unsigned eff_width();
        if (img_width < 3) return 3;
        if (img_width > LINE_DEPTH) return LINE_DEPTH;
        return img_width;
    endfunction

    function automatic int unsigned eff_height();
        return (img_height < 3) ? 3 : img_height;
    endfunction

    // Advance the window by one accepted pixel and queue the sum it completes
    task automatic step_window(input logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        int unsigned acc;
        int          dx;
        int          dy;
        logic [PIX_W-1:0] taps [3][3];
        t_result     res;
        w   = eff_width();
        h   = eff_height();
        c   = col_cnt;
        r   = row_cnt;
        idx = c % LINE_DEPTH;
        for (dy = 0; dy < 3; dy++) begin
            taps[0][dy] = win_cols[dy];
            taps[1][dy] = win_cols[3+dy];
        end
        taps[2][2] = px;
        taps[2][1] = line_mem[idx];
        taps[2][0] = line_mem[LINE_DEPTH+idx];
        line_mem[LINE_DEPTH+idx] = taps[2][1];
        line_mem[idx]            = taps[2][2];
        if (c >= 2 && r >= 2) begin
            acc = 0;
            for (dx = 0; dx < 3; dx++) begin
                for (dy = 0; dy < 3; dy++) begin
                    acc += taps[dx][dy] * (11 + 3*dx + dy);
                end
            end
            res.pixel = 8'(acc);
            res.col   = COL_OUT_W'(c - 2);
            res.row   = ROW_W'(r - 2);
            res.last  = (c + 1 >= w) && (r + 1 >= h);
            pending_sums.insert(pending_sums.size(), res);
        end
        for (dy = 0; dy < 3; dy++) begin
            win_cols[dy]   = taps[1][dy];
            win_cols[3+dy] = taps[2][dy];
        end
        if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input t_fill mode, input int k);
        case (mode)
            FILL_ZEROS:     return 8'h00;
            FILL_ONES:      return 8'hFF;
            FILL_ALTERNATE: return k[0] ? 8'h55 : 8'hAA;
            default: begin
                case ($urandom_range(9))
                    0:       return 8'h00;
                    1:       return 8'hFF;
                    default: return 8'($urandom);
                endcase
            end
        endcase
    endfunction

    // Leave valid high on return so back-to-back transactions need no extra step
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 35) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= px;
        do @(posedge i_clk); while (!o_in_ready);
        step_window(px);
        sent_count++;
    endtask

    task automatic send_pixels(input int count, input t_fill mode);
        int k;
        for (k = 0; k < count; k++) begin
            send_pixel(pick_pixel(mode, k));
        end
    endtask

    // Stream until the raster position returns to the frame origin
    task automatic send_rest_of_frame(input t_fill mode);
        int k;
        k = 0;
        do begin
            send_pixel(pick_pixel(mode, k));
            k++;
        end while (col_cnt != 0 || row_cnt != 0);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_sums.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_IMAGE_WIDTH) begin
            img_width = data[IMG_WIDTH_W-1:0];
        end else begin
            img_height = data;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] width_data,
                            input logic [CFG_DATA_W-1:0] height_data);
        write_register(CFG_IMAGE_WIDTH, width_data);
        write_register(CFG_IMAGE_HEIGHT, height_data);
    endtask

    // Full 64-pixel lines at the reset width; only the height is shortened
    task automatic test_reset_width_frame();
        write_register(CFG_IMAGE_HEIGHT, 12'd3);
        send_rest_of_frame(FILL_RANDOM);
        drain_results();
    endtask

    task automatic test_pixel_extremes();
        set_size(12'hF83, 12'd3);
        send_rest_of_frame(FILL_ONES);
        drain_results();
        // zero and tiny sizes clamp to the 3x3 minimum
        set_size(12'h000, 12'h000);
        send_rest_of_frame(FILL_ZEROS);
        drain_results();
        set_size(12'd2, 12'd2);
        send_rest_of_frame(FILL_ALTERNATE);
        drain_results();
    endtask

    task automatic test_width_saturation();
        set_size(12'hFFF, 12'd3);
        send_rest_of_frame(FILL_RANDOM);
        drain_results();
    endtask

    task automatic test_counter_beyond_size();
        // shrink width while the column already lies past the new limit
        set_size(12'd20, 12'd6);
        send_pixels(2*20 + 15, FILL_RANDOM);
        drain_results();
        set_size(12'd8, 12'd3);
        send_rest_of_frame(FILL_RANDOM);
        drain_results();
        // tallest frame, cut short once the row is past the new height
        set_size(12'd10, 12'd4095);
        send_pixels(5*10 + 4, FILL_RANDOM);
        drain_results();
        set_size(12'd6, 12'd4);
        send_rest_of_frame(FILL_RANDOM);
        drain_results();
    endtask

    task automatic test_full_rate_stream();
        gaps_on = 1'b0;
        set_size(12'd32, 12'd8);
        send_rest_of_frame(FILL_RANDOM);
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_frames(input int target);
        int start;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        start = sent_count;
        while (sent_count - start < target) begin
            case ($urandom_range(11))
                0:       w = $urandom_range(0, 127);
                1:       w = LINE_DEPTH;
                default: w = $urandom_range(3, 16);
            endcase
            h = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            set_size({5'($urandom), 7'(w)}, 12'(h));
            if ($urandom_range(5) == 0) begin
                // broken frame: resize mid-frame, never wider than the lines already stored
                n = $urandom_range(1, eff_width() * eff_height() - 1);
                send_pixels(n, FILL_RANDOM);
                drain_results();
                set_size({5'($urandom), 7'($urandom_range(0, eff_width()))},
                         12'($urandom_range(0, 8)));
            end
            send_rest_of_frame(FILL_RANDOM);
            drain_results();
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_pixel_in  = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        gaps_on     = 1'b1;
        error_count = 0;
        sent_count  = 0;
        cycle_count = 0;
        img_width   = IMG_WIDTH_RST;
        img_height  = IMG_HEIGHT_RST;
        col_cnt     = 0;
        row_cnt     = 0;
        foreach (line_mem[k]) line_mem[k] = '0;
        foreach (win_cols[k]) win_cols[k] = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_width_frame();
        test_pixel_extremes();
        test_width_saturation();
        test_counter_beyond_size();
        test_full_rate_stream();
        test_random_frames(320);

        drain_results();
        if (pending_sums.size() != 0) begin
            report_error($sformatf("%0d results never arrived", pending_sums.size()));
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
